// ===== src/bfc_pkg.sv =====
// Shared constants, codes and control structs for the background frame calibration block.
package bfc_pkg;

    localparam int MAX_FRAME_PIXELS_DEF = 4096;
    localparam int MAX_CAL_FRAMES_DEF   = 15;
    localparam int PIXEL_BITS_DEF       = 16;

    localparam int CAL_MIN   = 3;
    localparam int DEPTH_MIN = 8;

    localparam int IN_W  = 16;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CFG_IW-1:0] CFG_CAL_FRAMES = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_METHOD     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_OPERATION  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RUNNING    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DEPTH      = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PIXELS     = 3'd5;

    localparam logic [1:0] EST_MEDIAN = 2'd0;
    localparam logic [1:0] EST_MEAN   = 2'd1;
    localparam logic [1:0] EST_MAX    = 2'd2;
    localparam logic [1:0] EST_MIN    = 2'd3;

    localparam logic [1:0] OP_SUB = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic load;
        logic est_clear;
        logic fs_rd;
        logic fs_wr;
        logic use_s;
        logic bg_rd;
        logic bg_wr;
        logic b_load_est;
        logic b_load_bg;
        logic b_load_div;
        logic mul_load;
        logic div_start;
        logic div_mean;
        logic res_load_fast;
        logic res_load_div;
        logic res_pass;
        logic out_load;
        logic out_corr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic b_zero;
    } sts_t;

endpackage

// ===== src/bfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bfc_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = VW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/bfc_datapath.sv =====
// Frame and background stores, per-pixel estimate, apply arithmetic and output register.
module bfc_datapath #(
    parameter int MFP = 4096,
    parameter int MCF = 15,
    parameter int PB  = 16,
    parameter int NW  = 4,
    parameter int PW  = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          pixel_in,
    input  logic                 eof_in,
    input  bfc_pkg::cmd_t        cmd,
    output bfc_pkg::sts_t        sts,
    input  logic [NW-1:0]        slot,
    input  logic [PW-1:0]        pos,
    input  logic [NW-1:0]        cal_n,
    input  logic [1:0]           method,
    input  logic [1:0]           op,
    input  logic [PB-1:0]        maxv,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_pixel,
    output logic                 out_corr,
    output logic                 out_last
);
    import bfc_pkg::*;

    localparam int FS_DEPTH = MCF * MFP;
    localparam int AW  = $clog2(FS_DEPTH);
    localparam int IW  = $clog2(MCF);
    localparam int SW  = PB + NW;
    localparam int DW  = 2 * PB;

    logic [PB-1:0] fs_mem [FS_DEPTH];
    logic [PB-1:0] bg_mem [MFP];

    logic [PB-1:0] s_reg, fs_q, bg_q, b_reg, res_reg, mx_reg, mn_reg;
    logic          eof_reg, rd_v_reg, use_s_reg;
    logic [PB-1:0] srt_reg [MCF];
    logic [PB-1:0] srt_next [MCF];
    logic [NW-1:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [DW-1:0] prod_reg;
    logic          out_valid_reg, out_corr_reg, out_last_reg;
    logic [15:0]   out_pixel_reg;

    logic [PB-1:0] pin_sat, val, prv [MCF], est_val, fast_val, q_clamp;
    logic          gt [MCF];
    logic          gtp [MCF];
    logic [AW-1:0] fa;
    logic [NW-1:0] half;
    logic [PB:0]   add_sum;
    logic [DW-1:0] div_a, quo;
    logic [PB-1:0] div_b;
    logic          div_done;

    assign pin_sat = (pixel_in > 16'(maxv)) ? maxv : pixel_in[PB-1:0];
    assign fa      = AW'(int'(slot) * MFP + int'(pos));
    assign val     = use_s_reg ? s_reg : fs_q;
    assign half    = cal_n >> 1;

    always_ff @(posedge clk)
    begin
        if (cmd.fs_wr)
        begin
            fs_mem[fa] <= s_reg;
        end
        if (cmd.fs_rd)
        begin
            fs_q <= fs_mem[fa];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bg_wr)
        begin
            bg_mem[pos] <= b_reg;
        end
        if (cmd.bg_rd)
        begin
            bg_q <= bg_mem[pos];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MCF; i++)
        begin
            gt[i] = (NW'(i) < cnt_reg) && (srt_reg[i] > val);
        end
        prv[0] = val;
        gtp[0] = 1'b0;
        for (int i = 1; i < MCF; i++)
        begin
            prv[i] = srt_reg[i-1];
            gtp[i] = gt[i-1];
        end
        for (int i = 0; i < MCF; i++)
        begin
            if (gt[i] || NW'(i) == cnt_reg)
            begin
                srt_next[i] = gtp[i] ? prv[i] : val;
            end
            else
            begin
                srt_next[i] = srt_reg[i];
            end
        end
    end

    always_comb
    begin
        case (method)
            EST_MEDIAN: est_val = srt_reg[half[IW-1:0]];
            EST_MAX:    est_val = (mx_reg > maxv) ? maxv : mx_reg;
            EST_MIN:    est_val = mn_reg;
            default:    est_val = q_clamp;
        endcase
    end

    assign q_clamp = (quo > DW'(maxv)) ? maxv : quo[PB-1:0];
    assign add_sum = {1'b0, s_reg} + {1'b0, b_reg};

    always_comb
    begin
        case (op)
            OP_SUB:  fast_val = (s_reg > b_reg) ? PB'(s_reg - b_reg) : '0;
            OP_ADD:  fast_val = (add_sum > {1'b0, maxv}) ? maxv : add_sum[PB-1:0];
            OP_MUL:  fast_val = s_reg;
            default: fast_val = maxv;
        endcase
    end

    assign div_a = cmd.div_mean ? DW'(sum_reg) : prod_reg;
    assign div_b = cmd.div_mean ? PB'(cal_n) : ((op == OP_MUL) ? maxv : b_reg);

    bfc_div #(
        .DW(DW),
        .VW(PB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg   <= pin_sat;
            eof_reg <= eof_in;
        end
        if (cmd.est_clear)
        begin
            sum_reg <= '0;
            mx_reg  <= '0;
            mn_reg  <= maxv;
        end
        else if (rd_v_reg)
        begin
            for (int i = 0; i < MCF; i++)
            begin
                srt_reg[i] <= srt_next[i];
            end
            sum_reg <= sum_reg + SW'(val);
            if (val > mx_reg)
            begin
                mx_reg <= val;
            end
            if (val < mn_reg)
            begin
                mn_reg <= val;
            end
        end
        if (cmd.b_load_est || cmd.b_load_div)
        begin
            b_reg <= est_val;
        end
        else if (cmd.b_load_bg)
        begin
            b_reg <= bg_q;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= (op == OP_MUL) ? s_reg * b_reg : s_reg * maxv;
        end
        if (cmd.res_load_fast)
        begin
            res_reg <= fast_val;
        end
        else if (cmd.res_load_div)
        begin
            res_reg <= q_clamp;
        end
        else if (cmd.res_pass)
        begin
            res_reg <= s_reg;
        end
        if (cmd.out_load)
        begin
            out_pixel_reg <= 16'(res_reg);
            out_corr_reg  <= cmd.out_corr;
            out_last_reg  <= eof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            use_s_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.fs_rd;
            use_s_reg <= cmd.use_s;
            if (cmd.est_clear)
            begin
                cnt_reg <= '0;
            end
            else if (rd_v_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.div_done = div_done;
    assign sts.b_zero   = (b_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_corr  = out_corr_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/bfc_ctrl.sv =====
// Configuration registers, frame bookkeeping and the per-pixel sequencer.
module bfc_ctrl #(
    parameter int MFP = 4096,
    parameter int MCF = 15,
    parameter int PB  = 16,
    parameter int NW  = 4,
    parameter int PW  = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_action,
    input  logic                        in_eof,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bfc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [bfc_pkg::CFG_DW-1:0]  cfg_data,
    output bfc_pkg::cmd_t               cmd,
    input  bfc_pkg::sts_t               sts,
    output logic [NW-1:0]               slot,
    output logic [PW-1:0]               pos,
    output logic [NW-1:0]               cal_n,
    output logic [1:0]                  method,
    output logic [1:0]                  op,
    output logic [PB-1:0]               maxv
);
    import bfc_pkg::*;

    localparam int FPW = $clog2(MFP + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WRITE  = 4'd1;
    localparam logic [3:0] ST_SWEEP  = 4'd2;
    localparam logic [3:0] ST_DRAIN  = 4'd3;
    localparam logic [3:0] ST_EST    = 4'd4;
    localparam logic [3:0] ST_MDIV   = 4'd5;
    localparam logic [3:0] ST_BGRD   = 4'd6;
    localparam logic [3:0] ST_BGWAIT = 4'd7;
    localparam logic [3:0] ST_APPLY  = 4'd8;
    localparam logic [3:0] ST_DIVGO  = 4'd9;
    localparam logic [3:0] ST_ADIV   = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [3:0]     state_reg, state_next;
    logic [NW-1:0]  n_reg, held_reg, oldest_reg, wslot_reg, k_reg, n_m1;
    logic [1:0]     method_reg, op_reg;
    logic           running_reg, done_reg, bypass_reg, bgwr_reg, corr_reg;
    logic [4:0]     depth_reg;
    logic [FPW-1:0] fp_reg;
    logic [PW-1:0]  pos_reg, jpos_reg;
    logic           accept;

    logic [NW:0]    cn;
    logic [4:0]     dn;
    logic [31:0]    fw;
    logic [FPW-1:0] fpn;
    logic [PB:0]    full;
    logic [FPW:0]   pos_inc;

    assign n_m1 = n_reg - 1'b1;

    always_comb
    begin
        cn = (NW+1)'(cfg_data[3:0]);
        if (cn < (NW+1)'(CAL_MIN))
        begin
            cn = (NW+1)'(CAL_MIN);
        end
        if (!cn[0])
        begin
            cn = cn + 1'b1;
        end
        if (cn > (NW+1)'(MCF))
        begin
            cn = (NW+1)'(MCF - ((MCF % 2 == 0) ? 1 : 0));
        end
        dn = cfg_data[4:0];
        if (dn < 5'(DEPTH_MIN))
        begin
            dn = 5'(DEPTH_MIN);
        end
        if (dn > 5'(PB))
        begin
            dn = 5'(PB);
        end
        fw = 32'(cfg_data);
        if (fw == 32'd0)
        begin
            fw = 32'd1;
        end
        if (fw > 32'(MFP))
        begin
            fw = 32'(MFP);
        end
        fpn = FPW'(fw);
    end

    assign full    = ((PB+1)'(1) << depth_reg) - 1'b1;
    assign maxv    = full[PB-1:0];
    assign pos_inc = (FPW+1)'(pos_reg) + 1'b1;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load      = accept && !in_action;
                cmd.est_clear = accept && !in_action;
                if (accept && !in_action)
                begin
                    if (running_reg)
                    begin
                        state_next = (held_reg >= n_reg) ? ST_SWEEP : ST_WRITE;
                    end
                    else if (done_reg)
                    begin
                        state_next = ST_BGRD;
                    end
                    else
                    begin
                        state_next = (held_reg >= n_m1) ? ST_SWEEP : ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.fs_wr    = 1'b1;
                cmd.res_pass = 1'b1;
                state_next   = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.fs_rd = 1'b1;
                cmd.fs_wr = (k_reg == wslot_reg);
                cmd.use_s = bypass_reg && (k_reg == wslot_reg);
                if (k_reg == n_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EST;
            end
            ST_EST:
            begin
                if (method_reg == EST_MEAN)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mean  = 1'b1;
                    state_next    = ST_MDIV;
                end
                else
                begin
                    cmd.b_load_est = 1'b1;
                    state_next     = ST_APPLY;
                end
            end
            ST_MDIV:
            begin
                cmd.div_mean = 1'b1;
                if (sts.div_done)
                begin
                    cmd.b_load_div = 1'b1;
                    state_next     = ST_APPLY;
                end
            end
            ST_BGRD:
            begin
                cmd.bg_rd  = 1'b1;
                state_next = ST_BGWAIT;
            end
            ST_BGWAIT:
            begin
                cmd.b_load_bg = 1'b1;
                state_next    = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.bg_wr = bgwr_reg;
                if (op_reg == OP_SUB || op_reg == OP_ADD || (op_reg == OP_DIV && sts.b_zero))
                begin
                    cmd.res_load_fast = 1'b1;
                    state_next        = ST_DONE;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_ADIV;
            end
            ST_ADIV:
            begin
                if (sts.div_done)
                begin
                    cmd.res_load_div = 1'b1;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.out_corr = corr_reg;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= NW'(CAL_MIN);
            method_reg  <= EST_MEDIAN;
            op_reg      <= OP_SUB;
            running_reg <= 1'b0;
            depth_reg   <= 5'(PB);
            fp_reg      <= FPW'(MFP);
            held_reg    <= '0;
            oldest_reg  <= '0;
            pos_reg     <= '0;
            done_reg    <= 1'b0;
            wslot_reg   <= '0;
            k_reg       <= '0;
            jpos_reg    <= '0;
            bypass_reg  <= 1'b0;
            bgwr_reg    <= 1'b0;
            corr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                logic restart;
                restart = 1'b0;
                unique case (cfg_index)
                    CFG_CAL_FRAMES:
                    begin
                        restart = (n_reg != cn[NW-1:0]);
                        n_reg   <= cn[NW-1:0];
                    end
                    CFG_METHOD:
                    begin
                        restart    = (method_reg != cfg_data[1:0]);
                        method_reg <= cfg_data[1:0];
                    end
                    CFG_OPERATION:
                    begin
                        op_reg <= cfg_data[1:0];
                    end
                    CFG_RUNNING:
                    begin
                        restart     = (running_reg != cfg_data[0]);
                        running_reg <= cfg_data[0];
                    end
                    CFG_DEPTH:
                    begin
                        restart   = (depth_reg != dn);
                        depth_reg <= dn;
                    end
                    CFG_PIXELS:
                    begin
                        restart = (fp_reg != fpn);
                        fp_reg  <= fpn;
                    end
                    default:
                    begin
                        restart = 1'b0;
                    end
                endcase
                if (restart)
                begin
                    held_reg   <= '0;
                    oldest_reg <= '0;
                    pos_reg    <= '0;
                    done_reg   <= 1'b0;
                end
            end
            if (accept && in_action)
            begin
                held_reg   <= '0;
                oldest_reg <= '0;
                pos_reg    <= '0;
                done_reg   <= 1'b0;
            end
            else if (accept)
            begin
                jpos_reg   <= pos_reg;
                k_reg      <= '0;
                bypass_reg <= 1'b0;
                bgwr_reg   <= 1'b0;
                corr_reg   <= 1'b0;
                if (in_eof || pos_inc >= (FPW+1)'(fp_reg))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (running_reg)
                begin
                    if (held_reg >= n_reg)
                    begin
                        wslot_reg <= oldest_reg;
                        corr_reg  <= 1'b1;
                        if (in_eof)
                        begin
                            oldest_reg <= (oldest_reg == n_m1) ? '0 : oldest_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wslot_reg <= held_reg;
                        if (in_eof)
                        begin
                            held_reg <= held_reg + 1'b1;
                        end
                    end
                end
                else if (done_reg)
                begin
                    corr_reg <= 1'b1;
                end
                else if (held_reg >= n_m1)
                begin
                    wslot_reg  <= n_m1;
                    bypass_reg <= 1'b1;
                    bgwr_reg   <= 1'b1;
                    corr_reg   <= 1'b1;
                    if (in_eof)
                    begin
                        done_reg <= 1'b1;
                        held_reg <= '0;
                    end
                end
                else
                begin
                    wslot_reg <= held_reg;
                    if (in_eof)
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign slot   = (state_reg == ST_SWEEP) ? k_reg : wslot_reg;
    assign pos    = jpos_reg;
    assign cal_n  = n_reg;
    assign method = method_reg;
    assign op     = op_reg;

endmodule

// ===== src/background_frame_calibration.sv =====
// Top level of the background frame calibration block.
// Pixels are taken one at a time. A pixel that is only stored or passed goes from the write
// step to the output register; one corrected against the held background reads it first,
// then forms subtract, add or a divide by a zero background directly, and multiply or divide
// in the bit-serial divider. A pixel that builds the estimate reads the N held frames through
// the single frame-store read port, one per cycle, and the mean is formed in that divider too.
// A finished result waits in the output register while the next pixel is accepted.
module background_frame_calibration
    import bfc_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF,
    parameter int MAX_CAL_FRAMES   = MAX_CAL_FRAMES_DEF,
    parameter int PIXEL_BITS       = PIXEL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // pixel_in
    input  logic [0:0]          s_tuser,    // action
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,    // pixel_out
    output logic [0:0]          m_tuser,    // corrected
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data
);
    localparam int NW = $clog2(MAX_CAL_FRAMES + 1);
    localparam int PW = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;

    cmd_t                cmd;
    sts_t                sts;
    logic [NW-1:0]       slot, cal_n;
    logic [PW-1:0]       pos;
    logic [1:0]          method, op;
    logic [PIXEL_BITS-1:0] maxv;

    bfc_ctrl #(
        .MFP(MAX_FRAME_PIXELS),
        .MCF(MAX_CAL_FRAMES),
        .PB (PIXEL_BITS),
        .NW (NW),
        .PW (PW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser[0]),
        .in_eof    (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .slot      (slot),
        .pos       (pos),
        .cal_n     (cal_n),
        .method    (method),
        .op        (op),
        .maxv      (maxv)
    );

    bfc_datapath #(
        .MFP(MAX_FRAME_PIXELS),
        .MCF(MAX_CAL_FRAMES),
        .PB (PIXEL_BITS),
        .NW (NW),
        .PW (PW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (s_tdata),
        .eof_in    (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .slot      (slot),
        .pos       (pos),
        .cal_n     (cal_n),
        .method    (method),
        .op        (op),
        .maxv      (maxv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_corr  (m_tuser[0]),
        .out_last  (m_tlast)
    );

    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
        else $error("pixel request accepted while sequencer busy");

    a_frames_odd: assert property (@(posedge clk) disable iff (!rst_n)
        cal_n[0] && cal_n >= NW'(CAL_MIN))
        else $error("calibration frame count not odd or below minimum");

    a_out_scale: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> m_tdata <= 16'(maxv))
        else $error("result above full scale");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the background frame calibration block.
`timescale 1ns / 1ps

module testbench;
    import bfc_pkg::*;

    localparam int PIX_MAX = 4096;
    localparam int CAL_MAX = 15;

    typedef struct packed {
        logic        action;
        logic [15:0] pixel;
        logic        eof;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        corrected;
        logic        eof;
    } pixel_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;

    background_frame_calibration dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    pixel_req_t pending_pixels[$];
    pixel_res_t expected_pixels[$];
    int         errors = 0;
    int         tx_idle = 37;
    int         rx_idle = 66;
    bit         hold_req = 0;
    int         hold_left = 0;
    logic       s_fire = 1'b0;

    // shadow of the block
    logic [15:0] fs_mem[CAL_MAX*PIX_MAX];
    bit          fs_written[CAL_MAX*PIX_MAX];
    logic [15:0] bg_mem[PIX_MAX];
    bit          bg_written[PIX_MAX];
    int unsigned n_frames = CAL_MIN, method = EST_MEDIAN, operation = OP_SUB;
    int unsigned running = 0, depth = 16, frame_len = PIX_MAX;
    int unsigned held = 0, oldest = 0, position = 0;
    bit          cal_done = 0;

    function automatic int unsigned full_scale();
        return (1 << depth) - 1;
    endfunction

    function automatic void restart_shadow();
        held = 0;
        oldest = 0;
        position = 0;
        cal_done = 0;
    endfunction

    function automatic void shadow_config(int idx, int unsigned val);
        int unsigned nv;
        case (idx)
            CFG_CAL_FRAMES:
            begin
                nv = val & 4'hF;
                if (nv < CAL_MIN) nv = CAL_MIN;
                if (nv % 2 == 0) nv++;
                if (nv > CAL_MAX) nv = CAL_MAX;
                if (nv != n_frames) begin n_frames = nv; restart_shadow(); end
            end
            CFG_METHOD:
            begin
                nv = val & 3;
                if (nv != method) begin method = nv; restart_shadow(); end
            end
            CFG_OPERATION: operation = val & 3;
            CFG_RUNNING:
            begin
                nv = val & 1;
                if (nv != running) begin running = nv; restart_shadow(); end
            end
            CFG_DEPTH:
            begin
                nv = val & 5'h1F;
                if (nv < DEPTH_MIN) nv = DEPTH_MIN;
                if (nv > 16) nv = 16;
                if (nv != depth) begin depth = nv; restart_shadow(); end
            end
            CFG_PIXELS:
            begin
                nv = val & 13'h1FFF;
                if (nv < 1) nv = 1;
                if (nv > PIX_MAX) nv = PIX_MAX;
                if (nv != frame_len) begin frame_len = nv; restart_shadow(); end
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned estimate_bg(int unsigned pos, int unsigned maxv);
        int unsigned v[CAL_MAX];
        int unsigned x, acc;
        int j;
        for (int k = 0; k < n_frames; k++) v[k] = 32'(fs_mem[k*PIX_MAX + pos]);
        case (method)
            EST_MEDIAN:
            begin
                for (int k = 1; k < n_frames; k++)
                begin
                    x = v[k];
                    j = k;
                    while (j > 0 && v[j-1] > x) begin v[j] = v[j-1]; j--; end
                    v[j] = x;
                end
                return v[n_frames/2];
            end
            EST_MEAN:
            begin
                acc = 0;
                for (int k = 0; k < n_frames; k++) acc += v[k];
                acc /= n_frames;
                return acc > maxv ? maxv : acc;
            end
            EST_MAX:
            begin
                acc = 0;
                for (int k = 0; k < n_frames; k++) if (v[k] > acc) acc = v[k];
                return acc > maxv ? maxv : acc;
            end
            default:
            begin
                acc = maxv;
                for (int k = 0; k < n_frames; k++) if (v[k] < acc) acc = v[k];
                return acc;
            end
        endcase
    endfunction

    function automatic int unsigned correct_pixel(int unsigned s, int unsigned b,
                                                  int unsigned maxv);
        longint unsigned r;
        case (operation)
            OP_SUB: return s > b ? s - b : 0;
            OP_ADD: r = longint'(s) + b;
            OP_MUL: r = (longint'(s) * b) / maxv;
            default:
            begin
                if (b == 0) return maxv;
                r = (longint'(s) * maxv) / b;
            end
        endcase
        return r > maxv ? maxv : int'(r);
    endfunction

    function automatic void store_frame(int unsigned slot, int unsigned pos, int unsigned s);
        fs_mem[slot*PIX_MAX + pos] = 16'(s);
        fs_written[slot*PIX_MAX + pos] = 1;
    endfunction

    function automatic void predict_pixel(pixel_req_t req);
        int unsigned maxv, s, res, bg, slot, pos;
        bit corr;
        pixel_res_t r;
        maxv = full_scale();
        pos = position;
        corr = 0;
        if (req.action)
        begin
            restart_shadow();
            return;
        end
        s = req.pixel > maxv ? maxv : 32'(req.pixel);
        res = s;
        if (running)
        begin
            if (held >= n_frames)
            begin
                bg = estimate_bg(pos, maxv);
                res = correct_pixel(s, bg, maxv);
                corr = 1;
                store_frame(oldest % n_frames, pos, s);
            end
            else
                store_frame(held, pos, s);
            if (req.eof)
            begin
                if (held >= n_frames) oldest = (oldest + 1) % n_frames;
                else held++;
            end
        end
        else if (cal_done)
        begin
            res = correct_pixel(s, 32'(bg_mem[pos]), maxv);
            corr = 1;
        end
        else
        begin
            slot = held >= n_frames - 1 ? n_frames - 1 : held;
            store_frame(slot, pos, s);
            if (slot == n_frames - 1)
            begin
                bg = estimate_bg(pos, maxv);
                bg_mem[pos] = 16'(bg);
                bg_written[pos] = 1;
                res = correct_pixel(s, bg, maxv);
                corr = 1;
                if (req.eof) begin cal_done = 1; held = 0; end
            end
            else if (req.eof)
                held++;
        end
        position = (req.eof || pos + 1 >= frame_len) ? 0 : pos + 1;
        r.pixel = 16'(res);
        r.corrected = corr;
        r.eof = req.eof;
        expected_pixels.insert(expected_pixels.size(), r);
    endfunction

    // early frame end allowed once calibrated, else only if the slot's rest holds data
    function automatic bit early_end_safe(int unsigned p);
        int unsigned slot;
        bit calib;
        calib = 0;
        if (running)
            slot = held >= n_frames ? oldest % n_frames : held;
        else if (cal_done)
            return 1;
        else
        begin
            slot = held >= n_frames - 1 ? n_frames - 1 : held;
            calib = (slot == n_frames - 1);
        end
        for (int unsigned q = p + 1; q < frame_len; q++)
        begin
            if (!fs_written[slot*PIX_MAX + q]) return 0;
            if (calib && !bg_written[q]) return 0;
        end
        return 1;
    endfunction

    task automatic push_pixel(logic action, logic [15:0] pixel, logic eof);
        pixel_req_t req;
        req.action = action;
        req.pixel = pixel;
        req.eof = eof;
        pending_pixels.insert(pending_pixels.size(), req);
        predict_pixel(req);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(int idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IW'(idx);
        cfg_data <= CFG_DW'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_config(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_pixels.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] random_pixel();
        int unsigned maxv;
        maxv = full_scale();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'(maxv);
            2: return 16'hFFFF;
            3: return 16'($urandom_range(0, 15));
            4: return 16'($urandom);
            default: return 16'($urandom & maxv);
        endcase
    endfunction

    task automatic random_items(int count);
        int unsigned roll;
        logic eof;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                push_pixel(1'b1, random_pixel(), 1'($urandom_range(0, 1)));
            else
            begin
                eof = (position == frame_len - 1) && ($urandom_range(0, 19) != 0);
                if (roll < 6 && early_end_safe(position)) eof = 1'b1;
                push_pixel(1'b0, random_pixel(), eof);
            end
        end
    endtask

    always @(posedge clk)
        s_fire <= s_tvalid && s_tready;

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= tx_idle)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_pixels[0].action;
                s_tdata <= pending_pixels[0].pixel;
                s_tlast <= pending_pixels[0].eof;
                pending_pixels.delete(0);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 600;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        pixel_res_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                want = expected_pixels[0];
                expected_pixels.delete(0);
                if (m_tdata !== want.pixel)
                    report_mismatch("pixel_out", int'(m_tdata), int'(want.pixel));
                if (m_tuser[0] !== want.corrected)
                    report_mismatch("corrected", int'(m_tuser[0]), int'(want.corrected));
                if (m_tlast !== want.eof)
                    report_mismatch("frame_end_out", int'(m_tlast), int'(want.eof));
            end
        end
    end

    initial
    begin
        #(12 * 3_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, full-length frame, no frame end yet
        push_pixel(1'b0, 16'h0000, 1'b0);
        push_pixel(1'b0, 16'hFFFF, 1'b0);
        push_pixel(1'b0, 16'h8000, 1'b0);
        push_pixel(1'b0, 16'h0001, 1'b0);
        push_pixel(1'b0, 16'h7FFF, 1'b0);
        wait_drained();
        write_reg(CFG_PIXELS, 13'h1FFF);
        write_reg(6, 1);
        write_reg(7, 2);
        push_pixel(1'b0, 16'h5555, 1'b0);
        push_pixel(1'b0, 16'hAAAA, 1'b0);
        wait_drained();

        // depth 8 saturation and divide by a zero background
        write_reg(CFG_CAL_FRAMES, 0);
        write_reg(CFG_DEPTH, 0);
        write_reg(CFG_PIXELS, 0);
        write_reg(CFG_PIXELS, 2);
        write_reg(CFG_OPERATION, OP_DIV);
        push_pixel(1'b0, 16'h0000, 1'b0);
        push_pixel(1'b0, 16'h012C, 1'b1);
        push_pixel(1'b0, 16'h0000, 1'b0);
        push_pixel(1'b0, 16'h0005, 1'b1);
        push_pixel(1'b0, 16'h0000, 1'b0);
        push_pixel(1'b0, 16'h00FF, 1'b1);
        push_pixel(1'b0, 16'h0007, 1'b0);
        push_pixel(1'b0, 16'hFFFF, 1'b0);
        push_pixel(1'b0, 16'h0009, 1'b0);
        push_pixel(1'b0, 16'h0003, 1'b1);
        push_pixel(1'b1, 16'h0000, 1'b0);
        push_pixel(1'b0, 16'h0004, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3) begin tx_idle = 66; rx_idle = 37; end
            if (ph == 6) begin tx_idle = 0; rx_idle = 0; end
            write_reg(CFG_CAL_FRAMES, ph == 0 ? 15 : (ph == 1 ? 14 : $urandom_range(0, 15)));
            write_reg(CFG_METHOD, ph % 4);
            write_reg(CFG_OPERATION, $urandom_range(0, 3));
            write_reg(CFG_RUNNING, (ph / 2) % 2 ^ (ph % 2));
            write_reg(CFG_DEPTH, ph % 3 == 0 ? 31 : (ph % 3 == 1 ? 8 : $urandom_range(0, 31)));
            write_reg(CFG_PIXELS, ph == 0 ? 1 : $urandom_range(1, 8));
            if (ph == 1) hold_req = 1;
            random_items(95);
            wait_drained();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
